// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error("%m failed");
`define ASSERT_SEQ(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, cond)
`define ASSERT_SEQ(label, ante, cons)
`endif
`endif

// ----- rtl/core/pbcm_pkg.sv -----
// ----------------------------------------------------------------------------
// pbcm_pkg
// Types and constants for the page buffer clock manager.
// ----------------------------------------------------------------------------
package pbcm_pkg;

    localparam int FRAMES_DEF = 32;
    localparam int FRAME_W    = 5;
    localparam int CFG_W      = 17;
    localparam int OFF_W      = 40;
    localparam logic [15:0] PIN_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_GET   = 3'd0,
        OP_PIN   = 3'd1,
        OP_ALLOC = 3'd2,
        OP_DIRTY = 3'd3,
        OP_UNPIN = 3'd4,
        OP_FLUSH = 3'd5,
        OP_FORCE = 3'd6,
        OP_CLEAR = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_FRAME   = 3'd1,
        ST_BUFFERED   = 3'd2,
        ST_NOT_BUF    = 3'd3,
        ST_NOT_PINNED = 3'd4
    } status_t;

    localparam logic CFG_PAGE_BYTES   = 1'b0;
    localparam logic CFG_HEADER_BYTES = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  file_id;
        logic [23:0] page_num;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [4:0]  frame;
        logic [7:0]  req_file;
        logic [23:0] req_page;
        logic [39:0] byte_offset;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN1,
        S_SCAN2,
        S_VICTIM,
        S_WALK,
        S_MUL,
        S_EMIT,
        S_FINISH,
        S_DONE
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_item;
        logic lookup;
        logic scan_clear;
        logic scan_reset;
        logic scan_step;
        logic take_victim;
        logic evict_victim;
        logic do_hit;
        logic do_fill;
        logic do_clean;
        logic do_empty;
        logic walk_reset;
        logic walk_step;
        logic req_from_frame;
        logic req_from_item;
        logic mul_go;
        logic emit_req;
        logic emit_status;
        logic [2:0] status;
        logic use_frame;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic       hit;
        logic       pinned_zero;
        logic       scan_match;
        logic       scan_end;
        logic       victim_dirty;
        logic       walk_match;
        logic       walk_dirty;
        logic       walk_end;
        logic       out_busy;
        logic [2:0] op;
    } stat_t;

endpackage

// ----- rtl/core/pbcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbcm_ctrl
// Operation sequencer: lookup, victim scans, file walks and word emission.
// ----------------------------------------------------------------------------
module pbcm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  pbcm_pkg::stat_t st,
    output logic            busy,
    output pbcm_pkg::cmd_t  cmd
);
    import pbcm_pkg::*;
    `include "assert_macros.svh"

    state_t state_reg, state_next;
    // After a multiply the pending request kind and what follows.
    logic   after_walk_reg, after_walk_next;
    logic   read_pend_reg, read_pend_next;
    logic   is_read_reg, is_read_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            after_walk_reg <= 1'b0;
            read_pend_reg  <= 1'b0;
            is_read_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            after_walk_reg <= after_walk_next;
            read_pend_reg  <= read_pend_next;
            is_read_reg    <= is_read_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        after_walk_next = after_walk_reg;
        read_pend_next  = read_pend_reg;
        is_read_next    = is_read_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                    state_next = S_LOOKUP;
            S_LOOKUP:
            begin
                state_next = S_FINISH;
                unique case (op_t'(st.op))
                    OP_GET, OP_PIN, OP_ALLOC:
                        if (!st.hit)
                            state_next = S_SCAN1;
                    OP_FORCE:
                        if (st.hit && st.victim_dirty)
                        begin
                            after_walk_next = 1'b0;
                            read_pend_next  = 1'b0;
                            is_read_next    = 1'b0;
                            state_next      = S_MUL;
                        end
                    OP_FLUSH, OP_CLEAR:
                        state_next = S_WALK;
                    default:
                        state_next = S_FINISH;
                endcase
            end
            S_SCAN1:
                if (st.scan_match)
                    state_next = S_VICTIM;
                else if (st.scan_end)
                    state_next = S_SCAN2;
            S_SCAN2:
                if (st.scan_match)
                    state_next = S_VICTIM;
                else if (st.scan_end)
                    state_next = S_FINISH;
            S_VICTIM:
            begin
                after_walk_next = 1'b0;
                read_pend_next  = (op_t'(st.op) != OP_ALLOC);
                if (st.victim_dirty)
                begin
                    is_read_next = 1'b0;
                    state_next   = S_MUL;
                end
                else if (op_t'(st.op) != OP_ALLOC)
                begin
                    is_read_next   = 1'b1;
                    read_pend_next = 1'b0;
                    state_next     = S_MUL;
                end
                else
                    state_next = S_FINISH;
            end
            S_WALK:
                if (st.walk_match && st.walk_dirty)
                begin
                    after_walk_next = !st.walk_end;
                    read_pend_next  = 1'b0;
                    is_read_next    = 1'b0;
                    state_next      = S_MUL;
                end
                else if (st.walk_end)
                    state_next = S_FINISH;
            S_MUL:
                state_next = S_EMIT;
            S_EMIT:
                if (!st.out_busy)
                begin
                    if (read_pend_reg)
                    begin
                        read_pend_next = 1'b0;
                        is_read_next   = 1'b1;
                        state_next     = S_MUL;
                    end
                    else if (after_walk_reg)
                        state_next = S_WALK;
                    else
                        state_next = S_FINISH;
                end
            S_FINISH:
                if (!st.out_busy)
                    state_next = S_DONE;
            S_DONE:
                if (!st.out_busy)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // The status word is formed from latched flags in FINISH.
    logic scan_failed_reg, scan_failed_next;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_failed_reg <= 1'b0;
        else
            scan_failed_reg <= scan_failed_next;
    end

    always_comb
    begin
        scan_failed_next = scan_failed_reg;
        if (state_reg == S_LOOKUP)
            scan_failed_next = 1'b0;
        else if (state_reg == S_SCAN2 && !st.scan_match && st.scan_end)
            scan_failed_next = 1'b1;
    end

    logic hit_reg, hit_next;
    logic pz_reg, pz_next;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            pz_reg  <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
            pz_reg  <= pz_next;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        pz_next  = pz_reg;
        if (state_reg == S_LOOKUP)
        begin
            hit_next = st.hit;
            pz_next  = st.pinned_zero;
        end
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
                cmd.load_item = in_fire;
            S_LOOKUP:
            begin
                cmd.lookup     = 1'b1;
                cmd.scan_reset = 1'b1;
                cmd.walk_reset = 1'b1;
                if (op_t'(st.op) == OP_FORCE && st.hit)
                    cmd.req_from_frame = 1'b1;
            end
            S_SCAN1:
            begin
                cmd.scan_step  = 1'b1;
                cmd.scan_clear = 1'b1;
                cmd.take_victim = st.scan_match;
                cmd.scan_reset = st.scan_end && !st.scan_match;
            end
            S_SCAN2:
            begin
                cmd.scan_step   = 1'b1;
                cmd.take_victim = st.scan_match;
            end
            S_VICTIM:
            begin
                cmd.req_from_frame = 1'b1;
                cmd.evict_victim   = 1'b1;
            end
            S_WALK:
                if (st.walk_match)
                begin
                    cmd.req_from_frame = st.walk_dirty;
                    cmd.do_clean       = 1'b1;
                    cmd.do_empty       = (op_t'(st.op) == OP_CLEAR);
                    cmd.walk_step      = !(st.walk_dirty);
                end
                else
                    cmd.walk_step = 1'b1;
            S_MUL:
            begin
                cmd.mul_go        = 1'b1;
                cmd.req_from_item = is_read_reg;
            end
            S_EMIT:
                if (!st.out_busy)
                begin
                    cmd.emit_req  = 1'b1;
                    cmd.walk_step = after_walk_reg;
                end
            S_FINISH:
                if (!st.out_busy)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.status      = ST_OK;
                    cmd.use_frame   = 1'b0;
                    unique case (op_t'(st.op))
                        OP_GET, OP_PIN, OP_ALLOC:
                            if (hit_reg)
                            begin
                                cmd.use_frame = 1'b1;
                                cmd.do_hit    = 1'b1;
                                if (op_t'(st.op) == OP_ALLOC)
                                    cmd.status = ST_BUFFERED;
                            end
                            else if (scan_failed_reg)
                                cmd.status = ST_NO_FRAME;
                            else
                            begin
                                cmd.use_frame = 1'b1;
                                cmd.do_fill   = 1'b1;
                            end
                        OP_DIRTY:
                            if (!hit_reg)
                                cmd.status = ST_NOT_BUF;
                            else
                            begin
                                cmd.use_frame = 1'b1;
                                cmd.do_hit    = !pz_reg;
                                if (pz_reg)
                                    cmd.status = ST_NOT_PINNED;
                            end
                        OP_UNPIN:
                            if (!hit_reg)
                                cmd.status = ST_NOT_BUF;
                            else
                            begin
                                cmd.use_frame = 1'b1;
                                cmd.do_hit    = 1'b1;
                            end
                        OP_FORCE:
                        begin
                            cmd.use_frame = hit_reg;
                            cmd.do_clean  = hit_reg;
                        end
                        default:
                            cmd.use_frame = 1'b0;
                    endcase
                end
            default:
                cmd = '0;
        endcase
    end

    `ASSERT_SEQ(a_load_leaves_idle, in_fire, state_reg == S_LOOKUP)
    `ASSERT_IMPL(a_no_double_emit, !(cmd.emit_req && cmd.emit_status))
    `ASSERT_IMPL(a_fire_only_idle, !in_fire || state_reg == S_IDLE)
    `ASSERT_SEQ(a_mul_then_emit, state_reg == S_MUL, state_reg == S_EMIT)

endmodule

// ----- rtl/core/pbcm_datapath.sv -----
// ----------------------------------------------------------------------------
// pbcm_datapath
// Frame table, scan pointer, offset multiplier and output register.
// ----------------------------------------------------------------------------
module pbcm_datapath #(
    parameter int FRAMES = pbcm_pkg::FRAMES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbcm_pkg::in_item_t   in_item,
    input  pbcm_pkg::cmd_t       cmd,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [16:0]          cfg_data,
    output pbcm_pkg::stat_t      st,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pbcm_pkg::out_item_t  out_item
);
    import pbcm_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [16:0] page_bytes_reg, header_bytes_reg;
    in_item_t    item_reg;

    logic [FRAMES-1:0] valid_reg, dirty_reg, refb_reg;
    logic [7:0]        file_reg [FRAMES];
    logic [23:0]       page_reg [FRAMES];
    logic [15:0]       pin_reg  [FRAMES];

    logic [IW-1:0] idx_reg, ptr_reg, sel;
    logic          ptr_end;
    logic [7:0]    rq_file_reg;
    logic [23:0]   rq_page_reg;
    logic [IW-1:0] rq_frame_reg;
    logic [40:0]   prod_reg;
    logic          ovalid_reg;
    out_item_t     out_reg;

    // A request word is a read when it names the item being loaded.
    logic is_read_reg;

    function automatic logic [1:0] cmd_kind();
        return is_read_reg ? KIND_READ : KIND_WRITE;
    endfunction

    // Associative match on file and page, lowest frame wins.
    logic          hit_c;
    logic [IW-1:0] hit_idx_c;
    always_comb
    begin
        hit_c     = 1'b0;
        hit_idx_c = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
            if (valid_reg[i] && file_reg[i] == item_reg.file_id
                && page_reg[i] == item_reg.page_num)
            begin
                hit_c     = 1'b1;
                hit_idx_c = IW'(i);
            end
    end

    assign ptr_end = (ptr_reg == IW'(FRAMES - 1));
    assign sel     = cmd.req_from_frame && (cmd.do_clean || cmd.lookup) ? ptr_reg : idx_reg;

    always_comb
    begin
        st              = '0;
        st.op           = item_reg.op;
        st.hit          = hit_c;
        st.pinned_zero  = (pin_reg[hit_idx_c] == 16'd0);
        st.scan_match   = (pin_reg[ptr_reg] == 16'd0) && !refb_reg[ptr_reg];
        st.scan_end     = ptr_end;
        st.victim_dirty = cmd.lookup ? (valid_reg[hit_idx_c] && dirty_reg[hit_idx_c])
                                     : (valid_reg[idx_reg] && dirty_reg[idx_reg]);
        st.walk_match   = valid_reg[ptr_reg] && file_reg[ptr_reg] == item_reg.file_id;
        st.walk_dirty   = dirty_reg[ptr_reg];
        st.walk_end     = ptr_end;
        st.out_busy     = ovalid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_bytes_reg   <= 17'd4096;
            header_bytes_reg <= 17'd4096;
            valid_reg        <= '0;
            dirty_reg        <= '0;
            refb_reg         <= '0;
            ovalid_reg       <= 1'b0;
            for (int i = 0; i < FRAMES; i++)
            begin
                file_reg[i] <= '0;
                page_reg[i] <= '0;
                pin_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_PAGE_BYTES)
                    page_bytes_reg <= cfg_data;
                else
                    header_bytes_reg <= cfg_data;
            end
            if (cmd.scan_clear && pin_reg[ptr_reg] == 16'd0)
                refb_reg[ptr_reg] <= 1'b0;
            if (cmd.evict_victim)
                valid_reg[idx_reg] <= 1'b0;
            if (cmd.do_clean)
                dirty_reg[sel] <= 1'b0;
            if (cmd.do_empty)
            begin
                valid_reg[ptr_reg] <= 1'b0;
                file_reg[ptr_reg]  <= '0;
                page_reg[ptr_reg]  <= '0;
                pin_reg[ptr_reg]   <= '0;
            end
            if (cmd.do_hit)
            begin
                unique case (op_t'(item_reg.op))
                    OP_GET, OP_PIN:
                    begin
                        if (pin_reg[idx_reg] != PIN_MAX)
                            pin_reg[idx_reg] <= pin_reg[idx_reg] + 16'd1;
                        if (op_t'(item_reg.op) == OP_GET)
                            refb_reg[idx_reg] <= 1'b1;
                    end
                    OP_DIRTY:
                        dirty_reg[idx_reg] <= 1'b1;
                    OP_UNPIN:
                        if (pin_reg[idx_reg] != 16'd0)
                            pin_reg[idx_reg] <= pin_reg[idx_reg] - 16'd1;
                    default:
                        refb_reg[idx_reg] <= refb_reg[idx_reg];
                endcase
            end
            if (cmd.do_fill)
            begin
                valid_reg[idx_reg] <= 1'b1;
                file_reg[idx_reg]  <= item_reg.file_id;
                page_reg[idx_reg]  <= item_reg.page_num;
                pin_reg[idx_reg]   <= 16'd1;
                dirty_reg[idx_reg] <= 1'b0;
                if (op_t'(item_reg.op) != OP_PIN)
                    refb_reg[idx_reg] <= 1'b1;
            end
            if (cmd.emit_req || cmd.emit_status)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // Control-free payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_item;
        if (cmd.lookup)
            idx_reg <= hit_idx_c;
        if (cmd.take_victim)
            idx_reg <= ptr_reg;
        if (cmd.scan_reset || cmd.walk_reset)
            ptr_reg <= '0;
        else if (cmd.scan_step || cmd.walk_step)
            ptr_reg <= ptr_end ? '0 : ptr_reg + IW'(1);
        if (cmd.req_from_frame)
        begin
            rq_file_reg  <= file_reg[cmd.lookup ? hit_idx_c : sel];
            rq_page_reg  <= page_reg[cmd.lookup ? hit_idx_c : sel];
            rq_frame_reg <= cmd.lookup ? hit_idx_c : sel;
        end
        if (cmd.mul_go)
        begin
            if (cmd.req_from_item)
            begin
                rq_file_reg  <= item_reg.file_id;
                rq_page_reg  <= item_reg.page_num;
                rq_frame_reg <= idx_reg;
                prod_reg     <= 41'(item_reg.page_num * page_bytes_reg);
            end
            else
                prod_reg <= 41'(rq_page_reg * page_bytes_reg);
        end
        if (cmd.emit_req)
        begin
            out_reg.kind        <= cmd_kind();
            out_reg.status      <= ST_OK;
            out_reg.frame       <= 5'(rq_frame_reg);
            out_reg.req_file    <= rq_file_reg;
            out_reg.req_page    <= rq_page_reg;
            out_reg.byte_offset <= 40'(prod_reg + 41'(header_bytes_reg));
            out_reg.last        <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            out_reg.kind        <= KIND_STATUS;
            out_reg.status      <= cmd.status;
            out_reg.frame       <= cmd.use_frame ? 5'(idx_reg) : 5'd0;
            out_reg.req_file    <= '0;
            out_reg.req_page    <= '0;
            out_reg.byte_offset <= '0;
            out_reg.last        <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
            is_read_reg <= cmd.req_from_item;
    end

    assign out_valid = ovalid_reg;
    assign out_item  = out_reg;

    `ASSERT_IMPL(a_hold_on_stall, !(ovalid_reg && !out_ready) || !(cmd.emit_req || cmd.emit_status))
    `ASSERT_IMPL(a_fill_victim_free, !cmd.do_fill || !valid_reg[idx_reg])
    `ASSERT_SEQ(a_fill_sets_valid, cmd.do_fill, valid_reg[idx_reg])

endmodule

// ----- rtl/core/page_buffer_clock_manager_top.sv -----
// A hit's status word goes from LOOKUP to FINISH, where it is loaded into the output register.
// A miss adds up to two scans, one frame a cycle, and the MUL and EMIT steps of each request word,
// plus output stalls; flush and clear walk all FRAMES frames, each write-back word passing through MUL and EMIT.
// One operation at a time: the next input word is taken only once the sequencer is back in IDLE.
// Reset (rst_n, asynchronous, active low) empties every frame and
// restores page_bytes and header_bytes to 4096.
// ----------------------------------------------------------------------------
// page_buffer_clock_manager_top
// Buffer-pool frame manager with second-chance replacement.
// ----------------------------------------------------------------------------
module page_buffer_clock_manager_top #(
    parameter int FRAMES = pbcm_pkg::FRAMES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pbcm_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pbcm_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [16:0]         cfg_data
);
    import pbcm_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  busy;
    logic  in_fire;

    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;

    pbcm_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .st      (st),
        .busy    (busy),
        .cmd     (cmd)
    );

    pbcm_datapath #(
        .FRAMES (FRAMES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_data)
    );

endmodule

// ----- bench/page_buffer_clock_manager_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_buffer_clock_manager_top_test
// Drives buffer-pool operations into the frame manager and checks every
// read, write-back and status word against a behavioural frame pool.
// ----------------------------------------------------------------------------
module page_buffer_clock_manager_top_test;
    import pbcm_pkg::*;

    localparam int NFR = 32;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [16:0] cfg_data;

    page_buffer_clock_manager_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Behavioural copy of the frame pool.
    logic        fr_valid [NFR];
    logic [7:0]  fr_file  [NFR];
    logic [23:0] fr_page  [NFR];
    logic [15:0] fr_pins  [NFR];
    logic        fr_dirty [NFR];
    logic        fr_ref   [NFR];
    logic [16:0] page_size;
    logic [16:0] header_size;

    out_item_t pending_words[$];
    int        errors;
    int        send_idle;
    int        recv_stall;

    typedef struct {
        in_item_t  item;
        logic      typed;
        out_item_t word;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic out_item_t make_word(kind_t k, status_t s, int fr,
                                            logic [7:0] f, logic [23:0] p);
        out_item_t w;
        logic [63:0] off;
        off = 64'(p) * 64'(page_size) + 64'(header_size);
        w.kind        = k;
        w.status      = s;
        w.frame       = 5'(fr);
        w.req_file    = (k == KIND_STATUS) ? 8'd0 : f;
        w.req_page    = (k == KIND_STATUS) ? 24'd0 : p;
        w.byte_offset = (k == KIND_STATUS) ? 40'd0 : off[39:0];
        w.last        = (k == KIND_STATUS);
        return w;
    endfunction

    task automatic write_back_frame(int i);
        if (fr_valid[i] && fr_dirty[i])
            pending_words.push_back(make_word(KIND_WRITE, ST_OK, i, fr_file[i], fr_page[i]));
        fr_dirty[i] = 1'b0;
    endtask

    task automatic pick_victim(output int v);
        v = -1;
        for (int i = 0; i < NFR; i++)
            if (fr_pins[i] == 0)
            begin
                if (!fr_ref[i])
                begin
                    v = i;
                    break;
                end
                fr_ref[i] = 1'b0;
            end
        if (v < 0)
            for (int i = 0; i < NFR; i++)
                if (fr_pins[i] == 0 && !fr_ref[i])
                begin
                    v = i;
                    break;
                end
        if (v >= 0)
        begin
            write_back_frame(v);
            fr_valid[v] = 1'b0;
        end
    endtask

    task automatic predict_operation(in_item_t it);
        op_t op;
        int  hit;
        op  = op_t'(it.op);
        hit = -1;
        for (int i = 0; i < NFR; i++)
            if (fr_valid[i] && fr_file[i] == it.file_id && fr_page[i] == it.page_num)
            begin
                hit = i;
                break;
            end
        case (op)
            OP_GET, OP_PIN, OP_ALLOC:
            begin
                if (hit >= 0)
                begin
                    if (op == OP_ALLOC)
                    begin
                        pending_words.push_back(make_word(KIND_STATUS, ST_BUFFERED, hit, 0, 0));
                        return;
                    end
                    if (fr_pins[hit] != PIN_MAX)
                        fr_pins[hit]++;
                    if (op == OP_GET)
                        fr_ref[hit] = 1'b1;
                end
                else
                begin
                    pick_victim(hit);
                    if (hit < 0)
                    begin
                        pending_words.push_back(make_word(KIND_STATUS, ST_NO_FRAME, 0, 0, 0));
                        return;
                    end
                    if (op != OP_ALLOC)
                        pending_words.push_back(make_word(KIND_READ, ST_OK, hit,
                                                          it.file_id, it.page_num));
                    fr_valid[hit] = 1'b1;
                    fr_file[hit]  = it.file_id;
                    fr_page[hit]  = it.page_num;
                    fr_pins[hit]  = 16'd1;
                    fr_dirty[hit] = 1'b0;
                    if (op != OP_PIN)
                        fr_ref[hit] = 1'b1;
                end
                pending_words.push_back(make_word(KIND_STATUS, ST_OK, hit, 0, 0));
            end
            OP_DIRTY:
                if (hit < 0)
                    pending_words.push_back(make_word(KIND_STATUS, ST_NOT_BUF, 0, 0, 0));
                else if (fr_pins[hit] == 0)
                    pending_words.push_back(make_word(KIND_STATUS, ST_NOT_PINNED, hit, 0, 0));
                else
                begin
                    fr_dirty[hit] = 1'b1;
                    pending_words.push_back(make_word(KIND_STATUS, ST_OK, hit, 0, 0));
                end
            OP_UNPIN:
                if (hit < 0)
                    pending_words.push_back(make_word(KIND_STATUS, ST_NOT_BUF, 0, 0, 0));
                else
                begin
                    if (fr_pins[hit] != 0)
                        fr_pins[hit]--;
                    pending_words.push_back(make_word(KIND_STATUS, ST_OK, hit, 0, 0));
                end
            OP_FLUSH:
            begin
                for (int i = 0; i < NFR; i++)
                    if (fr_valid[i] && fr_file[i] == it.file_id)
                        write_back_frame(i);
                pending_words.push_back(make_word(KIND_STATUS, ST_OK, 0, 0, 0));
            end
            OP_FORCE:
            begin
                if (hit >= 0)
                    write_back_frame(hit);
                pending_words.push_back(make_word(KIND_STATUS, ST_OK,
                                                  (hit >= 0) ? hit : 0, 0, 0));
            end
            default:
            begin
                for (int i = 0; i < NFR; i++)
                    if (fr_valid[i] && fr_file[i] == it.file_id)
                    begin
                        write_back_frame(i);
                        fr_valid[i] = 1'b0;
                        fr_file[i]  = 8'd0;
                        fr_page[i]  = 24'd0;
                        fr_pins[i]  = 16'd0;
                    end
                pending_words.push_back(make_word(KIND_STATUS, ST_OK, 0, 0, 0));
            end
        endcase
    endtask

    // Result checker.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, out_data);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = pending_words.pop_front();
                if (out_data !== e)
                begin
                    $display("%0t: expected %h, actual %h", $time, e, out_data);
                    errors++;
                end
            end
        end

    always @(posedge clk or negedge rst_n)
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall);

    // Valid drops after each accepted word before the next word is driven,
    // so the next word never lands in the same time step as the drop.
    task automatic send_word(in_item_t it);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
            @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        predict_operation(it);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [16:0] val);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PAGE_BYTES)
            page_size = val;
        else
            header_size = val;
    endtask

    // Mostly a small working set so that hits, evictions and pins happen.
    function automatic in_item_t random_item();
        in_item_t it;
        it.op = 3'($urandom_range(7));
        if ($urandom_range(9) < 8)
        begin
            it.file_id  = 8'($urandom_range(3, 1));
            it.page_num = 24'($urandom_range(40));
        end
        else
        begin
            it.file_id  = 8'($urandom);
            it.page_num = 24'($urandom);
        end
        if (it.op == OP_UNPIN && $urandom_range(3) == 0)
            it.op = OP_UNPIN;
        return it;
    endfunction

    initial
    begin
        row_t rows[$];
        row_t r;
        out_item_t w;
        errors      = 0;
        send_idle   = 0;
        recv_stall  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_index   = 1'b0;
        cfg_data    = '0;
        page_size   = 17'd4096;
        header_size = 17'd4096;
        for (int i = 0; i < NFR; i++)
        begin
            fr_valid[i] = 0; fr_file[i] = 0; fr_page[i] = 0;
            fr_pins[i] = 0; fr_dirty[i] = 0; fr_ref[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; typed rows are known at a glance from the empty pool.
        r.typed = 1'b1;
        r.item = '{OP_UNPIN, 8'd1, 24'd0};
        r.word = make_word(KIND_STATUS, ST_NOT_BUF, 0, 0, 0);  rows.push_back(r);
        r.item = '{OP_DIRTY, 8'd255, 24'hFFFFFF};
        r.word = make_word(KIND_STATUS, ST_NOT_BUF, 0, 0, 0);  rows.push_back(r);
        r.item = '{OP_FORCE, 8'd1, 24'd5};
        r.word = make_word(KIND_STATUS, ST_OK, 0, 0, 0);       rows.push_back(r);
        r.typed = 1'b0;
        r.item = '{OP_GET,   8'd255, 24'hFFFFFF}; rows.push_back(r);
        r.item = '{OP_PIN,   8'd1,   24'd0};      rows.push_back(r);
        r.item = '{OP_ALLOC, 8'd1,   24'd0};      rows.push_back(r);
        r.item = '{OP_ALLOC, 8'd2,   24'd7};      rows.push_back(r);
        r.item = '{OP_DIRTY, 8'd255, 24'hFFFFFF}; rows.push_back(r);
        r.item = '{OP_DIRTY, 8'd1,   24'd0};      rows.push_back(r);
        r.item = '{OP_FORCE, 8'd1,   24'd0};      rows.push_back(r);
        r.item = '{OP_UNPIN, 8'd1,   24'd0};      rows.push_back(r);
        r.item = '{OP_UNPIN, 8'd1,   24'd0};      rows.push_back(r);
        r.item = '{OP_DIRTY, 8'd1,   24'd0};      rows.push_back(r);
        r.item = '{OP_FLUSH, 8'd255, 24'd0};      rows.push_back(r);
        r.item = '{OP_CLEAR, 8'd255, 24'd0};      rows.push_back(r);
        r.item = '{OP_GET,   8'd0,   24'd3};      rows.push_back(r);
        r.item = '{OP_CLEAR, 8'd2,   24'd0};      rows.push_back(r);
        r.item = '{OP_CLEAR, 8'd1,   24'd0};      rows.push_back(r);
        r.item = '{OP_CLEAR, 8'd0,   24'd0};      rows.push_back(r);

        // After each row is sent, the newest word queued is compared with the
        // status word given for a typed row.
        foreach (rows[k])
        begin
            send_word(rows[k].item);
            w = pending_words[$];
            if (rows[k].typed && w !== rows[k].word)
            begin
                $display("%0t: expected %h, actual %h", $time, rows[k].word, w);
                errors++;
            end
        end

        // Fill every frame pinned, then one more get finds no free frame.
        for (int i = 0; i < NFR; i++)
            send_word('{OP_PIN, 8'd9, 24'(i)});
        send_word('{OP_GET, 8'd9, 24'd100});
        send_word('{OP_CLEAR, 8'd9, 24'd0});

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_register(CFG_PAGE_BYTES, 17'd1);
                         write_register(CFG_HEADER_BYTES, 17'd0); end
                1: begin write_register(CFG_PAGE_BYTES, 17'h10000);
                         write_register(CFG_HEADER_BYTES, 17'h10000); end
                2: begin write_register(CFG_PAGE_BYTES, 17'h1FFFF);
                         write_register(CFG_HEADER_BYTES, 17'h1FFFF); end
                3: write_register(CFG_PAGE_BYTES, 17'd0);
                4: begin write_register(CFG_PAGE_BYTES, 17'($urandom));
                         write_register(CFG_HEADER_BYTES, 17'($urandom)); end
                default: ;
            endcase
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 76; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 76; end
                default: begin send_idle = 28; recv_stall = 28; end
            endcase
            for (int n = 0; n < 70; n++)
                send_word(random_item());
            // In the last phase a burst of gets on one page keeps its pin count high.
            if (ph == 5)
                for (int n = 0; n < 20; n++)
                    send_word('{OP_GET, 8'd1, 24'd1});
        end

        recv_stall = 0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
